FILE: rtl/h2hist_pkg.sv
package h2hist_pkg;

    // Store geometry: each axis has its bins plus an underflow and an overflow bin.
    localparam int MAX_X_BINS = 256;
    localparam int MAX_Y_BINS = 256;
    localparam int AXIS_MAX   = (MAX_X_BINS > MAX_Y_BINS) ? MAX_X_BINS : MAX_Y_BINS;
    localparam int CELL_COUNT = (MAX_X_BINS + 2) * (MAX_Y_BINS + 2);
    localparam int CELL_AW    = $clog2(CELL_COUNT);

    // A bin number runs from 0 to AXIS_MAX + 1.
    localparam int BIN_W  = $clog2(AXIS_MAX + 2);
    localparam int STEP_W = $clog2(BIN_W);
    localparam int PROD_W = 32 + BIN_W;

    typedef logic [1:0] opcode_t;
    localparam opcode_t OP_FILL  = 2'd0;
    localparam opcode_t OP_READ  = 2'd1;
    localparam opcode_t OP_CLEAR = 2'd2;

    typedef logic [2:0] cfg_idx_t;
    localparam cfg_idx_t CFG_X_BINS    = 3'd0;
    localparam cfg_idx_t CFG_Y_BINS    = 3'd1;
    localparam cfg_idx_t CFG_X_LOW     = 3'd2;
    localparam cfg_idx_t CFG_X_HIGH    = 3'd3;
    localparam cfg_idx_t CFG_Y_LOW     = 3'd4;
    localparam cfg_idx_t CFG_Y_HIGH    = 3'd5;
    localparam cfg_idx_t CFG_THRESHOLD = 3'd6;

    // Bin count in use: zero acts as one, anything above the maximum as the maximum.
    function automatic logic [BIN_W-1:0] eff_bins(input logic [8:0] r, input int maxb);
        logic [BIN_W-1:0] n;
        if (r == 9'd0)
        begin
            n = BIN_W'(1);
        end
        else if (int'(r) > maxb)
        begin
            n = BIN_W'(maxb);
        end
        else
        begin
            n = BIN_W'(r);
        end
        return n;
    endfunction

endpackage

FILE: rtl/hough_2d_histogram_accumulator.sv
// Two-dimensional histogram accumulator with overflow bins.
// Input channel (in_valid / in_stall): one word carries an opcode (fill, read or clear),
// the x and y operands with their coordinate flags, and a fill weight. A word is taken
// when in_valid is high and in_stall is low; in_stall stays high while a word is at work.
// Output channel (out_valid / out_stall): exactly one result word per input word, held in
// an output register until the receiver takes it. A stalled receiver only holds back the
// last step of the next word; the block still takes a new input word meanwhile.
// Configuration (cfg_valid / cfg_ready / cfg_index / cfg_data): cfg_ready is always high;
// write only while the block is idle.
// Processing: each axis first takes a range check; a bin-index operand needs nothing more,
// and a coordinate operand in range then takes one multiply and a nine-step restoring
// division on the shared divider. The address step follows, then, if both axes are in
// range, the read and update steps, then the result; the next word is taken after that.
// A clear sweeps the whole store one cell a cycle and then gives its result.
// Reset: all registers take their reset values and the store is swept to zero, during
// which in_stall is high; configuration writes are taken throughout.
module hough_2d_histogram_accumulator
    import h2hist_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [1:0]         opcode,
    input  logic               x_is_coord,
    input  logic               y_is_coord,
    input  logic signed [31:0] x_value,
    input  logic signed [31:0] y_value,
    input  logic signed [15:0] weight,
    output logic               out_valid,
    input  logic               out_stall,
    output logic signed [31:0] bin_content,
    output logic               in_range,
    output logic [31:0]        entry_total,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [2:0]         cfg_index,
    input  logic [31:0]        cfg_data
);

    localparam int CW = 2 * BIN_W + 2;

    typedef enum logic [3:0] {
        S_IDLE,
        S_RANGE,
        S_MUL,
        S_DIV,
        S_ADDR,
        S_READ,
        S_MOD,
        S_DONE,
        S_CLEAR
    } state_t;

    // Control and configuration registers.
    state_t             state_reg, state_next;
    logic [CELL_AW-1:0] clr_ptr_reg, clr_ptr_next;
    logic               clr_item_reg, clr_item_next;
    logic [31:0]        entry_reg, entry_next;
    logic               axis_reg, axis_next;
    logic [STEP_W-1:0]  step_reg, step_next;
    logic [8:0]         x_bins_reg, x_bins_next;
    logic [8:0]         y_bins_reg, y_bins_next;
    logic [31:0]        x_low_reg, x_low_next;
    logic [31:0]        x_high_reg, x_high_next;
    logic [31:0]        y_low_reg, y_low_next;
    logic [31:0]        y_high_reg, y_high_next;
    logic [31:0]        thr_reg, thr_next;

    // Latched input word and working values.
    opcode_t            op_reg, op_next;
    logic               xc_reg, xc_next;
    logic               yc_reg, yc_next;
    logic [31:0]        xv_reg, xv_next;
    logic [31:0]        yv_reg, yv_next;
    logic [15:0]        wt_reg, wt_next;
    logic [31:0]        diff_reg, diff_next;
    logic [31:0]        den_reg, den_next;
    logic [PROD_W-1:0]  num_reg, num_next;
    logic [BIN_W-1:0]   quo_reg, quo_next;
    logic [BIN_W-1:0]   bin_reg [2];
    logic [BIN_W-1:0]   bin_next [2];
    logic               ok_reg [2];
    logic               ok_next [2];
    logic [CELL_AW-1:0] addr_reg, addr_next;
    logic [31:0]        res_content_reg, res_content_next;
    logic               res_valid_reg, res_valid_next;

    // Output register.
    logic               out_valid_reg, out_valid_next;
    logic [31:0]        out_content_reg, out_content_next;
    logic               out_range_reg, out_range_next;
    logic [31:0]        out_entry_reg, out_entry_next;

    // Store port signals.
    logic               ram_we;
    logic [CELL_AW-1:0] ram_waddr;
    logic [31:0]        ram_wdata;
    logic               ram_re;
    logic [31:0]        ram_rdata;

    h2hist_ram #(
        .WIDTH (32),
        .DEPTH (CELL_COUNT)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (addr_reg),
        .rdata (ram_rdata)
    );

    // Axis operands selected for the shared range check, multiplier and divider.
    logic [BIN_W-1:0]   eff_x, eff_y, cur_n;
    logic               cur_coord;
    logic signed [32:0] v33, lo33, hi33, n33, diff33, span33;
    logic               span_ok, in_axis, idx_ok;
    logic [PROD_W-1:0]  den_shift;
    logic [PROD_W:0]    trial;
    logic [BIN_W-1:0]   quo_tmp;
    logic [CW-1:0]      cell_wide;
    logic signed [32:0] sum33;
    logic [31:0]        sat_sum;
    logic               axis_done;
    logic [BIN_W-1:0]   axis_bin;
    logic               axis_ok;

    assign eff_x = eff_bins(x_bins_reg, MAX_X_BINS);
    assign eff_y = eff_bins(y_bins_reg, MAX_Y_BINS);

    always_comb
    begin
        cur_coord = axis_reg ? yc_reg : xc_reg;
        cur_n     = axis_reg ? eff_y : eff_x;
        v33       = axis_reg ? {yv_reg[31], yv_reg} : {xv_reg[31], xv_reg};
        lo33      = axis_reg ? {y_low_reg[31], y_low_reg} : {x_low_reg[31], x_low_reg};
        hi33      = axis_reg ? {y_high_reg[31], y_high_reg} : {x_high_reg[31], x_high_reg};
        n33       = $signed(33'(cur_n));
        diff33    = v33 - lo33;
        span33    = hi33 - lo33;
        span_ok   = hi33 > lo33;
        in_axis   = (v33 >= lo33) && (v33 <= hi33);
        idx_ok    = (v33 >= 33'sd1) && (v33 <= n33);
    end

    // One restoring division step against the divisor shifted to the current bit.
    always_comb
    begin
        den_shift = PROD_W'(den_reg) << step_reg;
        trial     = {1'b0, num_reg} - {1'b0, den_shift};
        quo_tmp   = quo_reg;
        if (!trial[PROD_W])
        begin
            quo_tmp[step_reg] = 1'b1;
        end
    end

    // Cell address and saturating update.
    always_comb
    begin
        cell_wide = CW'(bin_reg[0]) + CW'(bin_reg[1]) * (CW'(eff_x) + CW'(2));
        sum33     = {ram_rdata[31], ram_rdata} + {{17{wt_reg[15]}}, wt_reg};
        if (sum33[32] != sum33[31])
        begin
            sat_sum = sum33[32] ? 32'h8000_0000 : 32'h7FFF_FFFF;
        end
        else
        begin
            sat_sum = sum33[31:0];
        end
    end

    // Sequencer.
    always_comb
    begin
        state_next       = state_reg;
        clr_ptr_next     = clr_ptr_reg;
        clr_item_next    = clr_item_reg;
        entry_next       = entry_reg;
        axis_next        = axis_reg;
        step_next        = step_reg;
        x_bins_next      = x_bins_reg;
        y_bins_next      = y_bins_reg;
        x_low_next       = x_low_reg;
        x_high_next      = x_high_reg;
        y_low_next       = y_low_reg;
        y_high_next      = y_high_reg;
        thr_next         = thr_reg;
        op_next          = op_reg;
        xc_next          = xc_reg;
        yc_next          = yc_reg;
        xv_next          = xv_reg;
        yv_next          = yv_reg;
        wt_next          = wt_reg;
        diff_next        = diff_reg;
        den_next         = den_reg;
        num_next         = num_reg;
        quo_next         = quo_reg;
        bin_next[0]      = bin_reg[0];
        bin_next[1]      = bin_reg[1];
        ok_next[0]       = ok_reg[0];
        ok_next[1]       = ok_reg[1];
        addr_next        = addr_reg;
        res_content_next = res_content_reg;
        res_valid_next   = res_valid_reg;
        out_valid_next   = out_valid_reg;
        out_content_next = out_content_reg;
        out_range_next   = out_range_reg;
        out_entry_next   = out_entry_reg;
        ram_we           = 1'b0;
        ram_waddr        = addr_reg;
        ram_wdata        = sat_sum;
        ram_re           = 1'b0;
        axis_done        = 1'b0;
        axis_bin         = '0;
        axis_ok          = 1'b0;

        // The receiver takes the waiting result word.
        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end

        // Configuration writes.
        if (cfg_valid)
        begin
            unique case (cfg_index)
                CFG_X_BINS:    x_bins_next = cfg_data[8:0];
                CFG_Y_BINS:    y_bins_next = cfg_data[8:0];
                CFG_X_LOW:     x_low_next  = cfg_data;
                CFG_X_HIGH:    x_high_next = cfg_data;
                CFG_Y_LOW:     y_low_next  = cfg_data;
                CFG_Y_HIGH:    y_high_next = cfg_data;
                CFG_THRESHOLD: thr_next    = cfg_data;
                default:       ;
            endcase
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    op_next          = opcode;
                    xc_next          = x_is_coord;
                    yc_next          = y_is_coord;
                    xv_next          = x_value;
                    yv_next          = y_value;
                    wt_next          = weight;
                    res_content_next = '0;
                    res_valid_next   = 1'b0;
                    axis_next        = 1'b0;
                    unique case (opcode)
                        OP_FILL, OP_READ:
                        begin
                            state_next = S_RANGE;
                        end
                        OP_CLEAR:
                        begin
                            entry_next    = '0;
                            clr_item_next = 1'b1;
                            clr_ptr_next  = '0;
                            state_next    = S_CLEAR;
                        end
                        default:
                        begin
                            state_next = S_DONE;
                        end
                    endcase
                end
            end

            S_RANGE:
            begin
                diff_next = diff33[31:0];
                den_next  = span33[31:0];
                if (!cur_coord)
                begin
                    axis_done = 1'b1;
                    axis_bin  = v33[BIN_W-1:0];
                    axis_ok   = idx_ok;
                end
                else if (span_ok && in_axis)
                begin
                    state_next = S_MUL;
                end
                else
                begin
                    axis_done = 1'b1;
                end
            end

            S_MUL:
            begin
                num_next   = PROD_W'(diff_reg) * PROD_W'(cur_n);
                quo_next   = '0;
                step_next  = STEP_W'(BIN_W - 1);
                state_next = S_DIV;
            end

            S_DIV:
            begin
                if (!trial[PROD_W])
                begin
                    num_next = trial[PROD_W-1:0];
                end
                quo_next = quo_tmp;
                if (step_reg == '0)
                begin
                    axis_done = 1'b1;
                    axis_bin  = quo_tmp + BIN_W'(1);
                    axis_ok   = quo_tmp < cur_n;
                end
                else
                begin
                    step_next = step_reg - STEP_W'(1);
                end
            end

            S_ADDR:
            begin
                if (ok_reg[0] && ok_reg[1])
                begin
                    addr_next  = cell_wide[CELL_AW-1:0];
                    state_next = S_READ;
                end
                else
                begin
                    state_next = S_DONE;
                end
            end

            S_READ:
            begin
                ram_re     = 1'b1;
                state_next = S_MOD;
            end

            S_MOD:
            begin
                res_valid_next = 1'b1;
                if (op_reg == OP_FILL)
                begin
                    ram_we           = 1'b1;
                    res_content_next = sat_sum;
                    if (entry_reg != 32'hFFFF_FFFF)
                    begin
                        entry_next = entry_reg + 32'd1;
                    end
                end
                else if ($signed(ram_rdata) < $signed(thr_reg))
                begin
                    res_content_next = '0;
                end
                else
                begin
                    res_content_next = ram_rdata;
                end
                state_next = S_DONE;
            end

            S_DONE:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_valid_next   = 1'b1;
                    out_content_next = res_content_reg;
                    out_range_next   = res_valid_reg;
                    out_entry_next   = entry_reg;
                    state_next       = S_IDLE;
                end
            end

            S_CLEAR:
            begin
                ram_we    = 1'b1;
                ram_waddr = clr_ptr_reg;
                ram_wdata = '0;
                if (clr_ptr_reg == CELL_AW'(CELL_COUNT - 1))
                begin
                    clr_ptr_next  = '0;
                    clr_item_next = 1'b0;
                    state_next    = clr_item_reg ? S_DONE : S_IDLE;
                end
                else
                begin
                    clr_ptr_next = clr_ptr_reg + CELL_AW'(1);
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        // An axis is finished: keep its bin and move to the other axis or the address step.
        if (axis_done)
        begin
            bin_next[axis_reg] = axis_bin;
            ok_next[axis_reg]  = axis_ok;
            if (!axis_reg)
            begin
                axis_next  = 1'b1;
                state_next = S_RANGE;
            end
            else
            begin
                state_next = S_ADDR;
            end
        end
    end

    // State and registered outputs.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_CLEAR;
            clr_ptr_reg     <= '0;
            clr_item_reg    <= 1'b0;
            entry_reg       <= '0;
            axis_reg        <= 1'b0;
            step_reg        <= '0;
            x_bins_reg      <= 9'd256;
            y_bins_reg      <= 9'd256;
            x_low_reg       <= 32'd0;
            x_high_reg      <= 32'd65535;
            y_low_reg       <= 32'd0;
            y_high_reg      <= 32'd65535;
            thr_reg         <= 32'd0;
            op_reg          <= OP_FILL;
            xc_reg          <= 1'b0;
            yc_reg          <= 1'b0;
            xv_reg          <= '0;
            yv_reg          <= '0;
            wt_reg          <= '0;
            diff_reg        <= '0;
            den_reg         <= '0;
            num_reg         <= '0;
            quo_reg         <= '0;
            bin_reg[0]      <= '0;
            bin_reg[1]      <= '0;
            ok_reg[0]       <= 1'b0;
            ok_reg[1]       <= 1'b0;
            addr_reg        <= '0;
            res_content_reg <= '0;
            res_valid_reg   <= 1'b0;
            out_valid_reg   <= 1'b0;
            out_content_reg <= '0;
            out_range_reg   <= 1'b0;
            out_entry_reg   <= '0;
        end
        else
        begin
            state_reg       <= state_next;
            clr_ptr_reg     <= clr_ptr_next;
            clr_item_reg    <= clr_item_next;
            entry_reg       <= entry_next;
            axis_reg        <= axis_next;
            step_reg        <= step_next;
            x_bins_reg      <= x_bins_next;
            y_bins_reg      <= y_bins_next;
            x_low_reg       <= x_low_next;
            x_high_reg      <= x_high_next;
            y_low_reg       <= y_low_next;
            y_high_reg      <= y_high_next;
            thr_reg         <= thr_next;
            op_reg          <= op_next;
            xc_reg          <= xc_next;
            yc_reg          <= yc_next;
            xv_reg          <= xv_next;
            yv_reg          <= yv_next;
            wt_reg          <= wt_next;
            diff_reg        <= diff_next;
            den_reg         <= den_next;
            num_reg         <= num_next;
            quo_reg         <= quo_next;
            bin_reg[0]      <= bin_next[0];
            bin_reg[1]      <= bin_next[1];
            ok_reg[0]       <= ok_next[0];
            ok_reg[1]       <= ok_next[1];
            addr_reg        <= addr_next;
            res_content_reg <= res_content_next;
            res_valid_reg   <= res_valid_next;
            out_valid_reg   <= out_valid_next;
            out_content_reg <= out_content_next;
            out_range_reg   <= out_range_next;
            out_entry_reg   <= out_entry_next;
        end
    end

    assign in_stall    = (state_reg != S_IDLE);
    assign cfg_ready   = 1'b1;
    assign out_valid   = out_valid_reg;
    assign bin_content = out_content_reg;
    assign in_range    = out_range_reg;
    assign entry_total = out_entry_reg;

endmodule

FILE: rtl/h2hist_ram.sv
module h2hist_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // One write port and one read port; read data appears the cycle after re.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule
